// ----- design/nocpi_pkg.sv -----
// ----------------------------------------------------------------------------
// nocpi_pkg
// Types and constants shared by the network interface modules.
// ----------------------------------------------------------------------------
package nocpi_pkg;

	localparam int FLIT_W = 16;
	localparam int ADDR_W = 32;
	localparam int CFG_IDX_W = 2;

	localparam logic [ADDR_W-1:0] FLIT_STEP = ADDR_W'(2);

	localparam logic [CFG_IDX_W-1:0] CFG_RECV_BASE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_SEND_BASE = CFG_IDX_W'(1);

	typedef enum logic [1:0] {
		PH_READY  = 2'd0,
		PH_LENGTH = 2'd1,
		PH_DATA   = 2'd2,
		PH_WAIT   = 2'd3
	} phase_t;

	typedef struct packed {
		logic              in_valid;
		logic [FLIT_W-1:0] in_flit;
		logic              ack;
		logic              start_req;
		logic [FLIT_W-1:0] send_word;
	} item_t;

	typedef struct packed {
		logic              in_pop;
		logic              recv_write;
		logic [ADDR_W-1:0] recv_addr;
		logic [FLIT_W-1:0] recv_data;
		logic              intr;
		logic              clear_ack;
		logic              clear_start;
		logic [ADDR_W-1:0] send_addr;
		logic              out_valid;
		logic [FLIT_W-1:0] out_flit;
	} result_t;

	typedef struct packed {
		logic              in_pop;
		logic              recv_write;
		logic [ADDR_W-1:0] recv_addr;
		logic [FLIT_W-1:0] recv_data;
		logic              intr;
		logic              clear_ack;
	} recv_res_t;

	typedef struct packed {
		logic              clear_start;
		logic [ADDR_W-1:0] send_addr;
		logic              out_valid;
		logic [FLIT_W-1:0] out_flit;
	} send_res_t;

endpackage

// ----- design/nocpi_recv.sv -----
// ----------------------------------------------------------------------------
// nocpi_recv
// Receive machine: header, length and data flits into receive memory,
// then interrupt until acknowledged.
// ----------------------------------------------------------------------------
module nocpi_recv (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  logic                          in_valid,
	input  logic [nocpi_pkg::FLIT_W-1:0]  in_flit,
	input  logic                          ack,
	input  logic [nocpi_pkg::ADDR_W-1:0]  recv_base,
	output nocpi_pkg::recv_res_t          res
);
	import nocpi_pkg::*;

	phase_t            phase_q, phase_d;
	logic [ADDR_W-1:0] addr_q, addr_d;
	logic [FLIT_W-1:0] rem_q, rem_d;
	logic              intr_q, intr_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_READY;
			addr_q  <= '0;
			rem_q   <= '0;
			intr_q  <= 1'b0;
		end else if (adv) begin
			phase_q <= phase_d;
			addr_q  <= addr_d;
			rem_q   <= rem_d;
			intr_q  <= intr_d;
		end
	end

	always_comb begin
		phase_d        = phase_q;
		addr_d         = addr_q;
		rem_d          = rem_q;
		intr_d         = intr_q;
		res            = '0;
		case (phase_q)
			PH_READY: begin
				if (!intr_q && in_valid) begin
					res.in_pop     = 1'b1;
					res.recv_write = 1'b1;
					res.recv_addr  = recv_base;
					res.recv_data  = in_flit;
					addr_d         = recv_base + FLIT_STEP;
					phase_d        = PH_LENGTH;
				end
			end
			PH_LENGTH: begin
				if (in_valid) begin
					res.in_pop     = 1'b1;
					res.recv_write = 1'b1;
					res.recv_addr  = addr_q;
					res.recv_data  = in_flit;
					addr_d         = addr_q + FLIT_STEP;
					rem_d          = in_flit;
					phase_d        = PH_DATA;
				end
			end
			PH_DATA: begin
				if (rem_q == '0) begin
					intr_d  = 1'b1;
					phase_d = PH_WAIT;
				end else if (in_valid) begin
					res.in_pop     = 1'b1;
					res.recv_write = 1'b1;
					res.recv_addr  = addr_q;
					res.recv_data  = in_flit;
					addr_d         = addr_q + FLIT_STEP;
					rem_d          = rem_q - FLIT_W'(1);
				end
			end
			default: begin
				if (ack) begin
					phase_d       = PH_READY;
					intr_d        = 1'b0;
					res.clear_ack = 1'b1;
				end
			end
		endcase
		res.intr = intr_d;
	end

endmodule

// ----- design/nocpi_send.sv -----
// ----------------------------------------------------------------------------
// nocpi_send
// Send machine: header, length and data flits are read from send memory
// and pushed to the router.
// ----------------------------------------------------------------------------
module nocpi_send (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  logic                          start_req,
	input  logic [nocpi_pkg::FLIT_W-1:0]  send_word,
	input  logic [nocpi_pkg::ADDR_W-1:0]  send_base,
	output nocpi_pkg::send_res_t          res
);
	import nocpi_pkg::*;

	phase_t            phase_q, phase_d;
	logic [ADDR_W-1:0] addr_q, addr_d;
	logic [FLIT_W-1:0] rem_q, rem_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_READY;
			addr_q  <= '0;
			rem_q   <= '0;
		end else if (adv) begin
			phase_q <= phase_d;
			addr_q  <= addr_d;
			rem_q   <= rem_d;
		end
	end

	always_comb begin
		phase_d = phase_q;
		addr_d  = addr_q;
		rem_d   = rem_q;
		res     = '0;
		case (phase_q)
			PH_LENGTH: begin
				res.out_valid = 1'b1;
				res.out_flit  = send_word;
				rem_d         = send_word;
				addr_d        = addr_q + FLIT_STEP;
				phase_d       = PH_DATA;
			end
			PH_DATA: begin
				if (rem_q == '0) begin
					phase_d         = PH_READY;
					res.clear_start = 1'b1;
					addr_d          = send_base;
				end else begin
					res.out_valid = 1'b1;
					res.out_flit  = send_word;
					rem_d         = rem_q - FLIT_W'(1);
					addr_d        = addr_q + FLIT_STEP;
				end
			end
			default: begin
				phase_d = PH_READY;
				if (start_req) begin
					res.out_valid = 1'b1;
					res.out_flit  = send_word;
					addr_d        = addr_q + FLIT_STEP;
					phase_d       = PH_LENGTH;
				end else begin
					addr_d = send_base;
				end
			end
		endcase
		res.send_addr = addr_d;
	end

endmodule

// ----- design/noc_packet_interface_top.sv -----
// ----------------------------------------------------------------------------
// noc_packet_interface_top
// Network interface: one tick per input beat, receive and send machines.
//
//   channel | dir | handshake             | payload
//   in      | in  | in_valid / in_ready   | in_data  (item_t)
//   out     | out | out_valid / out_ready | out_data (result_t)
//   cfg     | in  | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One beat per cycle sustained unless out_ready stalls; beats pass the input
// register, then the result register; both machines evaluate between the two.
// Reset clears both machines and the base registers; cfg_ready is always high.
// A stalled result holds in the result register while the input register
// still takes one more beat if it is empty.
// ----------------------------------------------------------------------------
module noc_packet_interface_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  nocpi_pkg::item_t                  in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output nocpi_pkg::result_t                out_data,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [nocpi_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [nocpi_pkg::ADDR_W-1:0]      cfg_data
);
	import nocpi_pkg::*;

	item_t             item_s1;
	logic              v_s1;
	logic              adv;
	logic [ADDR_W-1:0] recv_base_q, send_base_q;
	recv_res_t         rres;
	send_res_t         sres;
	result_t           res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recv_base_q <= '0;
			send_base_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_RECV_BASE: recv_base_q <= cfg_data;
				CFG_SEND_BASE: send_base_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign adv      = v_s1 && (!out_valid || out_ready);
	assign in_ready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

	nocpi_recv u_recv (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (item_s1.in_valid),
		.in_flit   (item_s1.in_flit),
		.ack       (item_s1.ack),
		.recv_base (recv_base_q),
		.res       (rres)
	);

	nocpi_send u_send (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.start_req (item_s1.start_req),
		.send_word (item_s1.send_word),
		.send_base (send_base_q),
		.res       (sres)
	);

	always_comb begin
		res.in_pop      = rres.in_pop;
		res.recv_write  = rres.recv_write;
		res.recv_addr   = rres.recv_addr;
		res.recv_data   = rres.recv_data;
		res.intr        = rres.intr;
		res.clear_ack   = rres.clear_ack;
		res.clear_start = sres.clear_start;
		res.send_addr   = sres.send_addr;
		res.out_valid   = sres.out_valid;
		res.out_flit    = sres.out_flit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (!out_valid || out_ready) begin
			out_valid <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data <= res;
		end
	end

	a_pop_needs_flit: assert property (@(posedge clk) disable iff (!arst_n)
		adv && res.in_pop |-> item_s1.in_valid)
		else $error("flit popped with no flit offered");

	a_clear_ack_needs_ack: assert property (@(posedge clk) disable iff (!arst_n)
		adv && res.clear_ack |-> item_s1.ack && !res.intr)
		else $error("ack cleared without ack or with interrupt still up");

	a_clear_start_no_push: assert property (@(posedge clk) disable iff (!arst_n)
		adv && res.clear_start |-> !res.out_valid && res.send_addr == send_base_q)
		else $error("send end beat pushed a flit or missed the base address");

	a_write_is_pop: assert property (@(posedge clk) disable iff (!arst_n)
		adv |-> res.recv_write == res.in_pop)
		else $error("receive write and pop disagree");

	a_result_taken: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid)
		else $error("processed beat produced no result");

endmodule
